FILE: rtl/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 8;
    localparam int CAP_W      = 8;
    localparam int GROUP_SIZE = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic cap;
        logic ins;
        logic del;
        logic rd;
    } plc_op_t;

endpackage

FILE: rtl/plc_cell.sv
`timescale 1ns / 1ps

module plc_cell #(
    parameter int IDX = 0
) (
    input  logic                        aclk,
    input  plc_pkg::plc_op_t            op,
    input  logic [plc_pkg::SLOT_W-1:0]  pos_idx,
    input  logic [plc_pkg::DATA_W-1:0]  item,
    input  logic [plc_pkg::DATA_W-1:0]  left_val,
    input  logic [plc_pkg::DATA_W-1:0]  right_val,
    output logic [plc_pkg::DATA_W-1:0]  cell_val,
    output logic [plc_pkg::DATA_W-1:0]  tap_val
);

    logic [plc_pkg::DATA_W-1:0] value_reg;
    logic [plc_pkg::DATA_W-1:0] tap_reg;
    logic                       hit;
    logic                       above;

    assign hit   = (int'(pos_idx) == IDX);
    assign above = (IDX > int'(pos_idx));

    always_ff @(posedge aclk) begin
        if (op.ins) begin
            if (hit) begin
                value_reg <= item;
            end else if (above) begin
                value_reg <= left_val;
            end
        end else if (op.del) begin
            if (hit || above) begin
                value_reg <= right_val;
            end
        end
        if (op.cap) begin
            tap_reg <= (op.rd && hit) ? value_reg : '0;
        end
    end

    assign cell_val = value_reg;
    assign tap_val  = tap_reg;

endmodule

FILE: rtl/plc_gather.sv
`timescale 1ns / 1ps

module plc_gather #(
    parameter int DEPTH = 128
) (
    input  logic                       aclk,
    input  logic [plc_pkg::DATA_W-1:0] tap_val [DEPTH],
    output logic [plc_pkg::DATA_W-1:0] gathered
);

    localparam int NG = (DEPTH + plc_pkg::GROUP_SIZE - 1) / plc_pkg::GROUP_SIZE;

    logic [plc_pkg::DATA_W-1:0] grp_reg  [NG];
    logic [plc_pkg::DATA_W-1:0] grp_next [NG];

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < plc_pkg::GROUP_SIZE; k++) begin
                if (g * plc_pkg::GROUP_SIZE + k < DEPTH) begin
                    grp_next[g] = grp_next[g] | tap_val[g * plc_pkg::GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NG; g++) begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb begin
        gathered = '0;
        for (int g = 0; g < NG; g++) begin
            gathered = gathered | grp_reg[g];
        end
    end

endmodule

FILE: rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values held in a row of cells, with
// insert, delete and read at a 1-based position; each transfer on the input
// gives exactly one result transfer carrying status, the new entry count and
// the read or removed value. All cells shift together in the cycle the input
// transfer is taken, and the selected entry is then collected through a
// two-level registered OR tree into the result register, which holds it
// until m_tready takes it.
// A new item is taken while the previous result still waits on the output.
// Inserts are refused as full once the count reaches the smaller of
// capacity_limit and DEPTH.

module positional_list_insert_delete #(
    parameter int DEPTH = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [plc_pkg::CAP_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func[1:0], item_value[33:2], slot_number[41:34], zero fill above
    input  logic [plc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], entry_count[9:2], read_value[41:10], zero fill above
    output logic [plc_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TAP  = 2'd1;
    localparam logic [1:0] PH_GRP  = 2'd2;

    logic [1:0]                        phase_reg;
    logic [1:0]                        phase_next;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [plc_pkg::CAP_W-1:0]         cap_reg;
    logic [plc_pkg::STATUS_W-1:0]      status_reg;
    logic [plc_pkg::STATUS_W-1:0]      status_next;
    logic [plc_pkg::CNT_OUT_W-1:0]     res_count_reg;
    logic                              m_valid_reg;
    logic [plc_pkg::M_TDATA_W-1:0]     m_data_reg;

    logic [plc_pkg::FUNC_W-1:0]        func;
    logic [plc_pkg::DATA_W-1:0]        item_value;
    logic [plc_pkg::SLOT_W-1:0]        slot_number;
    logic [plc_pkg::SLOT_W-1:0]        pos_idx;
    logic                              accept;
    logic                              is_full;
    logic                              ins_pos_ok;
    logic                              rd_pos_ok;
    logic                              ins_ok;
    logic                              del_ok;
    logic                              rd_ok;
    logic                              out_load;
    plc_pkg::plc_op_t                  op;
    logic [plc_pkg::DATA_W-1:0]        gathered;

    logic [plc_pkg::DATA_W-1:0]        val_w [DEPTH];
    logic [plc_pkg::DATA_W-1:0]        tap_w [DEPTH];

    assign func        = s_tdata[1:0];
    assign item_value  = s_tdata[33:2];
    assign slot_number = s_tdata[41:34];
    assign pos_idx     = slot_number - 1'b1;

    assign s_tready = (phase_reg == PH_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (phase_reg == PH_GRP) && (!m_valid_reg || m_tready);

    assign is_full = (int'(cap_reg) > DEPTH) ? (int'(count_reg) >= DEPTH)
                                             : (int'(count_reg) >= int'(cap_reg));
    assign ins_pos_ok = (slot_number != '0) && (int'(slot_number) <= int'(count_reg) + 1);
    assign rd_pos_ok  = (slot_number != '0) && (int'(slot_number) <= int'(count_reg));

    always_comb begin
        status_next = plc_pkg::ST_OK;
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        rd_ok       = 1'b0;
        case (func)
            plc_pkg::FUNC_INSERT: begin
                if (is_full) begin
                    status_next = plc_pkg::ST_FULL;
                end else if (!ins_pos_ok) begin
                    status_next = plc_pkg::ST_BADPOS;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            plc_pkg::FUNC_DELETE, plc_pkg::FUNC_READ: begin
                if (count_reg == '0) begin
                    status_next = plc_pkg::ST_EMPTY;
                end else if (!rd_pos_ok) begin
                    status_next = plc_pkg::ST_BADPOS;
                end else begin
                    rd_ok  = 1'b1;
                    del_ok = (func == plc_pkg::FUNC_DELETE);
                end
            end
            default: begin
                status_next = plc_pkg::ST_OK;
            end
        endcase
    end

    assign op.cap = accept;
    assign op.ins = accept && ins_ok;
    assign op.del = accept && del_ok;
    assign op.rd  = rd_ok;

    always_comb begin
        count_next = count_reg;
        if (op.ins) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (op.del) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (accept) begin
                    phase_next = PH_TAP;
                end
            end
            PH_TAP: begin
                phase_next = PH_GRP;
            end
            PH_GRP: begin
                if (out_load) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            cap_reg     <= plc_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            res_count_reg <= plc_pkg::CNT_OUT_W'(count_next);
        end
        if (out_load) begin
            m_data_reg <= {{(plc_pkg::M_TDATA_W - 42){1'b0}}, gathered,
                           res_count_reg, status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [plc_pkg::DATA_W-1:0] left_in;
        logic [plc_pkg::DATA_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_l
            assign left_in = val_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = val_w[i+1];
        end

        plc_cell #(
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .op        (op),
            .pos_idx   (pos_idx),
            .item      (item_value),
            .left_val  (left_in),
            .right_val (right_in),
            .cell_val  (val_w[i]),
            .tap_val   (tap_w[i])
        );
    end

    plc_gather #(
        .DEPTH (DEPTH)
    ) u_gather (
        .aclk     (aclk),
        .tap_val  (tap_w),
        .gathered (gathered)
    );

    a_tap_to_grp: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TAP) |=> (phase_reg == PH_GRP))
        else $error("Gather phase did not follow the tap capture.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= DEPTH)
        else $error("Entry count exceeds the number of cells.");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ins_ok) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("Accepted insert did not grow the list by one.");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (status_next != plc_pkg::ST_OK)) |=> $stable(count_reg))
        else $error("Rejected operation changed the entry count.");

endmodule
